@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default sizes of the queue.
	localparam int CAPACITY_DEF = 64;
	localparam int ID_SPACE_DEF = 256;
	localparam int KEY_BITS_DEF = 16;

	// Fixed field widths.
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	// Request type codes.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE
	} cell_cmd_t;

	// Control state of the top level.
	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

	// Access to the queued-flag store.
	typedef struct packed {
		logic            rd_en;
		logic [ID_W-1:0] rd_id;
		logic            wr_en;
		logic [ID_W-1:0] wr_id;
		logic            wr_flag;
	} flag_req_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key and an identifier and takes its
// neighbor's or the new entry on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
	input  logic                    clk,
	input  spq_pkg::cell_cmd_t      cmd,
	input  logic                    live,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [spq_pkg::ID_W-1:0] new_id,
	input  logic                    prev_ge,
	input  logic [KEY_BITS-1:0]     prev_key,
	input  logic [spq_pkg::ID_W-1:0] prev_id,
	input  logic [KEY_BITS-1:0]     next_key,
	input  logic [spq_pkg::ID_W-1:0] next_id,
	output logic [KEY_BITS-1:0]     key,
	output logic [spq_pkg::ID_W-1:0] id,
	output logic                    ge
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic [ID_W-1:0]     id_q;

	// The entry stays ahead of the new one when its key is greater or equal.
	assign ge  = live && (key_q >= new_key);
	assign key = key_q;
	assign id  = id_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_INSERT: begin
				if (!ge) begin
					if (prev_ge) begin
						key_q <= new_key;
						id_q  <= new_id;
					end else begin
						key_q <= prev_key;
						id_q  <= prev_id;
					end
				end
			end
			CMD_REMOVE: begin
				key_q <= next_key;
				id_q  <= next_id;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/spq_flags.sv @@
// ----------------------------------------------------------------------------
// spq_flags
// Queued-flag store, one bit per identifier, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module spq_flags #(
	parameter int ID_SPACE = spq_pkg::ID_SPACE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::flag_req_t req,
	output logic               rd_flag,
	output logic               busy
);
	import spq_pkg::*;

	localparam int FLAG_W  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
	localparam int ID_VALS = 1 << ID_W;

	logic              flag_mem [ID_SPACE];
	logic [FLAG_W-1:0] idx_tbl  [ID_VALS];
	logic [FLAG_W-1:0] clr_idx_q;
	logic              busy_q;
	logic              rd_flag_q;
	logic              we;
	logic [FLAG_W-1:0] widx;
	logic              wval;

	// Identifiers fold onto the flag space modulo ID_SPACE.
	for (genvar g = 0; g < ID_VALS; g++) begin : g_idx
		assign idx_tbl[g] = FLAG_W'(g % ID_SPACE);
	end

	assign we   = busy_q || req.wr_en;
	assign widx = busy_q ? clr_idx_q : idx_tbl[req.wr_id];
	assign wval = busy_q ? 1'b0 : req.wr_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			busy_q    <= 1'b1;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == FLAG_W'(ID_SPACE - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			flag_mem[widx] <= wval;
		end
		if (req.rd_en) begin
			rd_flag_q <= flag_mem[idx_tbl[req.rd_id]];
		end
	end

	assign rd_flag = rd_flag_q;
	assign busy    = busy_q;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of (identifier, key) entries kept in descending key order
// in a chain of cells, with a per-identifier queued flag.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Word
//   -------  --------------------  -----------------------------------------
//   request  in_valid / in_ready   req_type, entry_id, entry_key
//   result   out_valid / out_ready status, out_id, out_key, occupancy
//
// Each request is accepted in the idle state, where the queued flag of the
// identifier is read from the flag memory; in the execute state, once the
// result register is free, every cell compares its key with the new one and
// the chain shifts at once. After reset the flag memory is cleared, one entry
// per cycle; in_ready stays low during that pass.
// The result register holds one word. While it waits for out_ready the next
// request is still accepted, and its execute step waits for the register.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int ID_SPACE = spq_pkg::ID_SPACE_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [spq_pkg::ID_W-1:0]           entry_id,
	input  logic [KEY_BITS-1:0]                entry_key,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spq_pkg::STATUS_W-1:0]       status,
	output logic [spq_pkg::ID_W-1:0]           out_id,
	output logic [KEY_BITS-1:0]                out_key,
	output logic [$clog2(CAPACITY + 1)-1:0]    occupancy
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Control state.
	fsm_state_t state_q, state_d;
	logic [CNT_W-1:0] held_q;
	logic             out_valid_q;

	// Request captured at accept.
	logic                req_type_s1;
	logic [ID_W-1:0]     entry_id_s1;
	logic [KEY_BITS-1:0] entry_key_s1;

	// Result register.
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [CNT_W-1:0]    occupancy_q;

	// Chain signals.
	logic [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [ID_W-1:0]     cell_id  [CAPACITY];
	logic                cell_ge  [CAPACITY];
	logic                live     [CAPACITY];
	cell_cmd_t           cmd;

	// Flag store.
	flag_req_t flag_req;
	logic      flag_rd;
	logic      flag_busy;

	// Decision signals for the execute cycle.
	logic                accept;
	logic                fire;
	logic                out_free;
	logic                is_full;
	logic                is_empty;
	logic [STATUS_W-1:0] status_d;
	logic [CNT_W-1:0]    held_d;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign is_full  = (held_q == CNT_W'(CAPACITY));
	assign is_empty = (held_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (!flag_busy) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (in_valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_CLEAR;
			end
		endcase
	end

	// Outputs of the state machine: handshake, chain command, status.
	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		cmd      = CMD_HOLD;
		status_d = ST_EMPTY;
		held_d   = held_q;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
			end
			FSM_EXEC: begin
				fire = out_free;
				if (req_type_s1 == REQ_INSERT) begin
					// The duplicate check wins over the full check.
					if (flag_rd) begin
						status_d = ST_DUPLICATE;
					end else if (is_full) begin
						status_d = ST_FULL;
					end else begin
						status_d = ST_INSERTED;
						held_d   = held_q + 1'b1;
						if (out_free) begin
							cmd = CMD_INSERT;
						end
					end
				end else begin
					if (is_empty) begin
						status_d = ST_EMPTY;
					end else begin
						status_d = ST_REMOVED;
						held_d   = held_q - 1'b1;
						if (out_free) begin
							cmd = CMD_REMOVE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1  <= req_type;
			entry_id_s1  <= entry_id;
			entry_key_s1 <= entry_key;
		end
		if (fire) begin
			status_q    <= status_d;
			occupancy_q <= held_d;
			// Only a removal returns an entry; every other result carries zeros.
			if (status_d == ST_REMOVED) begin
				out_id_q  <= cell_id[0];
				out_key_q <= cell_key[0];
			end else begin
				out_id_q  <= '0;
				out_key_q <= '0;
			end
		end
	end

	// The flag is read on accept; it is set on a successful insert and
	// cleared for the head identifier on a removal.
	always_comb begin
		flag_req.rd_en   = accept;
		flag_req.rd_id   = entry_id;
		flag_req.wr_en   = (cmd == CMD_INSERT) || (cmd == CMD_REMOVE);
		flag_req.wr_id   = (cmd == CMD_INSERT) ? entry_id_s1 : cell_id[0];
		flag_req.wr_flag = (cmd == CMD_INSERT);
	end

	spq_flags #(
		.ID_SPACE(ID_SPACE)
	) u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (flag_req),
		.rd_flag(flag_rd),
		.busy   (flag_busy)
	);

	// The chain. Cell 0 is the head; a cell below the fill level holds an
	// entry. On insert every cell whose key is below the new key moves one
	// place back, and the first of them takes the new entry. On remove the
	// whole chain moves one place forward.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                prev_ge;
		logic [KEY_BITS-1:0] prev_key;
		logic [ID_W-1:0]     prev_id;
		logic [KEY_BITS-1:0] next_key;
		logic [ID_W-1:0]     next_id;

		assign live[g] = (CNT_W'(g) < held_q);

		if (g == 0) begin : g_head
			assign prev_ge  = 1'b1;
			assign prev_key = '0;
			assign prev_id  = '0;
		end else begin : g_body
			assign prev_ge  = cell_ge[g-1];
			assign prev_key = cell_key[g-1];
			assign prev_id  = cell_id[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign next_key = '0;
			assign next_id  = '0;
		end else begin : g_inner
			assign next_key = cell_key[g+1];
			assign next_id  = cell_id[g+1];
		end

		spq_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.live    (live[g]),
			.new_key (entry_key_s1),
			.new_id  (entry_id_s1),
			.prev_ge (prev_ge),
			.prev_key(prev_key),
			.prev_id (prev_id),
			.next_key(next_key),
			.next_id (next_id),
			.key     (cell_key[g]),
			.id      (cell_id[g]),
			.ge      (cell_ge[g])
		);
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_key   = out_key_q;
	assign occupancy = occupancy_q;

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. Requests go in on the
// request channel, and a shadow of the sorted store and of the queued flags
// predicts every result word. The predictions are compared field by field
// with the words that come out. The run covers ties, duplicates, a full
// store and empty removes, with random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int CAPACITY   = CAPACITY_DEF;
	localparam int ID_SPACE   = ID_SPACE_DEF;
	localparam int KEY_BITS   = KEY_BITS_DEF;
	localparam int OCC_W      = $clog2(CAPACITY + 1);
	localparam int CYCLE_CAP  = 400000;
	localparam int HOLD_LEN   = 300;
	localparam int TAIL_WAIT  = 8;

	// One result word as the queue reports it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     rid;
		logic [KEY_BITS-1:0] rkey;
		logic [OCC_W-1:0]    occ;
	} result_word_t;

	// Request mix of one random burst.
	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} burst_mode_t;

	// Shadow of the sorted store. Every accepted request word is applied here
	// at once, and the word it should produce waits in arrival order.
	class priority_shadow;
		logic [KEY_BITS-1:0] slot_key [CAPACITY];
		logic [ID_W-1:0]     slot_id  [CAPACITY];
		bit                  queued   [ID_SPACE];
		int                  held;
		int                  peak;
		int                  requests;
		int                  errors;
		int                  tally [8];
		result_word_t        awaited [$];

		function new();
			held = 0;
			peak = 0;
			requests = 0;
			errors = 0;
			foreach (queued[i])
				queued[i] = 1'b0;
			foreach (tally[i])
				tally[i] = 0;
		endfunction

		function void note_request(logic rt, logic [ID_W-1:0] id, logic [KEY_BITS-1:0] key);
			result_word_t w;
			int pos;
			int i;
			w = '0;
			if (rt == REQ_INSERT) begin
				// A queued identifier is refused before the full check.
				if (queued[id % ID_SPACE]) begin
					w.status = ST_DUPLICATE;
				end else if (held >= CAPACITY) begin
					w.status = ST_FULL;
				end else begin
					// The new entry goes behind every key that is not smaller.
					pos = 0;
					while (pos < held && slot_key[pos] >= key)
						pos++;
					for (i = held; i > pos; i--) begin
						slot_key[i] = slot_key[i-1];
						slot_id[i]  = slot_id[i-1];
					end
					slot_key[pos] = key;
					slot_id[pos]  = id;
					held++;
					queued[id % ID_SPACE] = 1'b1;
					w.status = ST_INSERTED;
				end
			end else begin
				if (held == 0) begin
					w.status = ST_EMPTY;
				end else begin
					w.rid  = slot_id[0];
					w.rkey = slot_key[0];
					for (i = 1; i < held; i++) begin
						slot_key[i-1] = slot_key[i];
						slot_id[i-1]  = slot_id[i];
					end
					held--;
					queued[w.rid % ID_SPACE] = 1'b0;
					w.status = ST_REMOVED;
				end
			end
			w.occ = held[OCC_W-1:0];
			if (held > peak)
				peak = held;
			requests++;
			tally[w.status]++;
			awaited.push_back(w);
		endfunction

		function void check_word(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
				logic [KEY_BITS-1:0] key, logic [OCC_W-1:0] occ);
			result_word_t w;
			if (awaited.size() == 0) begin
				$error("result word with nothing awaited: status %0d id %0d key %0d occ %0d",
					st, id, key, occ);
				errors++;
				return;
			end
			w = awaited.pop_front();
			if (st !== w.status) begin
				$error("status mismatch: expected %0d, actual %0d", w.status, st);
				errors++;
			end
			if (id !== w.rid) begin
				$error("out_id mismatch: expected %0d, actual %0d", w.rid, id);
				errors++;
			end
			if (key !== w.rkey) begin
				$error("out_key mismatch: expected %0h, actual %0h", w.rkey, key);
				errors++;
			end
			if (occ !== w.occ) begin
				$error("occupancy mismatch: expected %0d, actual %0d", w.occ, occ);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                req_type  = REQ_INSERT;
	logic [ID_W-1:0]     entry_id  = '0;
	logic [KEY_BITS-1:0] entry_key = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_id;
	logic [KEY_BITS-1:0] out_key;
	logic [OCC_W-1:0]    occupancy;

	priority_shadow book;

	// Idle rates in percent of cycles, set per phase by the stimulus process.
	int send_idle_pct = 27;
	int recv_idle_pct = 84;

	// A request for a long result stall, taken up by the receiver process.
	int hold_cycles_req = 0;
	int hold_left       = 0;
	int cycle_count     = 0;

	sorted_priority_queue #(
		.CAPACITY (CAPACITY),
		.ID_SPACE (ID_SPACE),
		.KEY_BITS (KEY_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.entry_id  (entry_id),
		.entry_key (entry_key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_id    (out_id),
		.out_key   (out_key),
		.occupancy (occupancy)
	);

	always #2 clk = ~clk;

	// Watchdog. The limit is far above the slowest correct run, including the
	// flag-clearing pass after reset and the long result stall.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side. A word counts when out_valid and out_ready were both high
	// at the edge. Then out_ready is chosen for the next cycle: low through a
	// requested stall, otherwise low at the current idle rate.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				book.check_word(status, out_id, out_key, occupancy);
			if (hold_cycles_req > 0) begin
				hold_left = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offers one request word and holds it until it is taken. The word is
	// applied to the shadow at the accepting edge. After that the sender idles
	// for each following cycle at the current idle rate; with no idle cycle,
	// in_valid stays high for the next word.
	task automatic offer(logic rt, logic [ID_W-1:0] id, logic [KEY_BITS-1:0] key);
		in_valid  <= 1'b1;
		req_type  <= rt;
		entry_id  <= id;
		entry_key <= key;
		do
			@(posedge clk);
		while (!in_ready);
		book.note_request(rt, id, key);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	// Stops offering and waits until every awaited word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Random requests in bursts. Fill bursts push the store to full, where
	// duplicates and full refusals show up; drain bursts run it empty; mixed
	// bursts sit in between. Keys lean on the extremes and on a few shared
	// values so that ties are common, and part of the identifiers come from a
	// small pool so that duplicates are common too.
	task automatic run_random(int count, bit start_full);
		burst_mode_t mode;
		int left;
		int ins_pct;
		int roll;
		logic rt;
		logic [ID_W-1:0] id;
		logic [KEY_BITS-1:0] key;
		mode = MODE_FILL;
		left = start_full ? 120 : $urandom_range(20, 80);
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				roll = $urandom_range(0, 2);
				mode = (roll == 0) ? MODE_FILL : (roll == 1) ? MODE_DRAIN : MODE_MIXED;
				left = $urandom_range(20, 80);
			end
			left--;
			case (mode)
				MODE_FILL:  ins_pct = 90;
				MODE_DRAIN: ins_pct = 15;
				default:    ins_pct = 50;
			endcase
			rt = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
			id = ($urandom_range(0, 99) < 30) ? ID_W'($urandom_range(0, 15))
				: ID_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 12)
				key = '0;
			else if (roll < 24)
				key = '1;
			else if (roll < 50)
				key = KEY_BITS'($urandom_range(1, 4) << (KEY_BITS - 4));
			else
				key = KEY_BITS'($urandom);
			offer(rt, id, key);
		end
	endtask

	initial begin
		book = new();

		// Reset once; the queue then clears its flag store with in_ready low,
		// which the first offer simply waits out.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words. The store starts empty, so the first remove reports
		// empty. Equal keys must come out in arrival order, a queued
		// identifier is refused, and an identifier may be reused once it has
		// been removed. Remove words carry extreme payloads that must be
		// ignored.
		offer(REQ_REMOVE, 8'hFF, '1);
		offer(REQ_INSERT, 8'd0, '0);
		offer(REQ_INSERT, 8'hFF, '1);
		offer(REQ_INSERT, 8'd0, '1);
		offer(REQ_INSERT, 8'd1, '1);
		offer(REQ_INSERT, 8'd2, '0);
		offer(REQ_INSERT, 8'd3, KEY_BITS'(1) << (KEY_BITS - 1));
		offer(REQ_INSERT, 8'hFF, '0);
		offer(REQ_REMOVE, 8'h00, '0);
		offer(REQ_REMOVE, 8'hFF, '1);
		offer(REQ_INSERT, 8'hFF, '0);
		offer(REQ_REMOVE, 8'hAA, 16'h5555);
		offer(REQ_REMOVE, 8'h55, 16'hAAAA);
		offer(REQ_REMOVE, 8'h00, '1);
		offer(REQ_REMOVE, 8'hFF, '0);
		offer(REQ_REMOVE, 8'h0F, '0);
		offer(REQ_INSERT, 8'hAA, 16'hAAAA);
		offer(REQ_INSERT, 8'h55, 16'h5555);
		offer(REQ_REMOVE, 8'h00, '0);
		offer(REQ_REMOVE, 8'h00, '0);
		offer(REQ_REMOVE, 8'h00, '0);

		// Slow sender, very slow receiver; the first burst fills the store.
		run_random(480, 1'b1);

		// Long result stall while the sender keeps offering back to back, so
		// that the queue backs up and stalls its request channel.
		send_idle_pct = 0;
		hold_cycles_req = HOLD_LEN;
		run_random(30, 1'b0);
		drain();

		// Very slow sender, slow receiver.
		send_idle_pct = 84;
		recv_idle_pct = 27;
		run_random(480, 1'b0);
		drain();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(480, 1'b1);

		drain();
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Covered %0d requests: %0d inserted, %0d duplicate, %0d full, %0d removed, %0d empty.",
			book.requests, book.tally[ST_INSERTED], book.tally[ST_DUPLICATE],
			book.tally[ST_FULL], book.tally[ST_REMOVED], book.tally[ST_EMPTY]);
		$display("Peak occupancy %0d of %0d, with a %0d-cycle result stall and idle phases on both sides.",
			book.peak, CAPACITY, HOLD_LEN);
		if (book.errors == 0 && book.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/spq_flags.sv
hw/rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
